// ===== hdl/sa_pkg.sv =====
// ----------------------------------------------------------------------------
// sa_pkg: shared types, constants and tables for the soft argmax normalizer
// Holds the queue item type, fixed-point table functions and register codes.
// ----------------------------------------------------------------------------
package sa_pkg;

    localparam int GROUP_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH     = 4;

    localparam int VALUE_W = 24;
    localparam int BETA_W  = 16;
    localparam int OUT_W   = 31;
    localparam int EXP_W   = 40;
    localparam int ISUM_W  = 30;
    localparam int ESUM_W  = 46;

    // register indexes
    localparam logic REG_BETA  = 1'b0;
    localparam logic REG_WHOLE = 1'b1;

    localparam logic [BETA_W-1:0] BETA_RESET = 16'd8192;

    // one classified sample on its way from front to back
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               drop;
    } t_sample;

    // exp(k), Q24.16, k = 0..16
    function automatic logic [EXP_W-1:0] int_exp(input logic [4:0] k);
        logic [EXP_W-1:0] r;
        case (k)
            5'd0:    r = 40'd65536;
            5'd1:    r = 40'd178145;
            5'd2:    r = 40'd484249;
            5'd3:    r = 40'd1316326;
            5'd4:    r = 40'd3578144;
            5'd5:    r = 40'd9726405;
            5'd6:    r = 40'd26439109;
            5'd7:    r = 40'd71868951;
            5'd8:    r = 40'd195360063;
            5'd9:    r = 40'd531043708;
            5'd10:   r = 40'd1443526462;
            5'd11:   r = 40'd3923911751;
            5'd12:   r = 40'd10666298010;
            5'd13:   r = 40'd28994004059;
            5'd14:   r = 40'd78813874367;
            5'd15:   r = 40'd214238322522;
            default: r = 40'd582360139072;
        endcase
        return r;
    endfunction

    // exp(2^-(j+1)), Q1.22, j = 0..15
    function automatic logic [22:0] frac_exp(input logic [3:0] j);
        logic [22:0] r;
        case (j)
            4'd0:    r = 23'd6915238;
            4'd1:    r = 23'd5385593;
            4'd2:    r = 23'd4752769;
            4'd3:    r = 23'd4464813;
            4'd4:    r = 23'd4327446;
            4'd5:    r = 23'd4260355;
            4'd6:    r = 23'd4227200;
            4'd7:    r = 23'd4210720;
            4'd8:    r = 23'd4202504;
            4'd9:    r = 23'd4198402;
            4'd10:   r = 23'd4196353;
            4'd11:   r = 23'd4195328;
            4'd12:   r = 23'd4194816;
            4'd13:   r = 23'd4194560;
            4'd14:   r = 23'd4194432;
            default: r = 23'd4194368;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/sa_front.sv =====
// ----------------------------------------------------------------------------
// sa_front: input acceptance and classification
// Accepts samples, marks those beyond the group depth as dropped.
// ----------------------------------------------------------------------------
module sa_front #(
    parameter int GROUP_DEPTH = sa_pkg::GROUP_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [sa_pkg::VALUE_W-1:0] i_s_tdata,
    input  logic                       i_s_tlast,
    input  logic                       i_full,
    output logic                       o_push,
    output sa_pkg::t_sample            o_item
);
    localparam int CW = $clog2(GROUP_DEPTH + 1);

    logic [CW-1:0] r_count, n_count;
    logic          drop;

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;
    assign drop       = (r_count == CW'(GROUP_DEPTH));

    assign o_item.value = i_s_tdata;
    assign o_item.last  = i_s_tlast;
    assign o_item.drop  = drop;

    // stored-sample count of the open group
    always_comb begin
        n_count = r_count;
        if (o_push) begin
            if (i_s_tlast)  n_count = '0;
            else if (!drop) n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= '0;
        else          r_count <= n_count;
    end
endmodule

// ===== hdl/sa_queue.sv =====
// ----------------------------------------------------------------------------
// sa_queue: short FIFO between front and back
// Holds classified samples so either side can stall on its own.
// ----------------------------------------------------------------------------
module sa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sa_pkg::t_sample i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output sa_pkg::t_sample o_item
);
    localparam int AW = $clog2(sa_pkg::QUEUE_DEPTH);

    sa_pkg::t_sample r_mem [sa_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_fill;

    assign o_full  = (r_fill == (AW+1)'(sa_pkg::QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_item  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + AW'(1);
            if (i_pop)  r_rp <= r_rp + AW'(1);
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + (AW+1)'(1);
                2'b01:   r_fill <= r_fill - (AW+1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end
endmodule

// ===== hdl/sa_back.sv =====
// ----------------------------------------------------------------------------
// sa_back: exponent, accumulation, normalization and output
// Sequencer with multiplies split into low and high halves and a bit-serial divider.
// ----------------------------------------------------------------------------
module sa_back #(
    parameter int GROUP_DEPTH = sa_pkg::GROUP_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_addr,
    input  logic [sa_pkg::BETA_W-1:0]  i_cfg_data,
    input  logic                       i_empty,
    input  sa_pkg::t_sample            i_item,
    output logic                       o_pop,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [31:0]                o_m_tdata,
    output logic                       o_m_tlast,
    output logic                       o_m_tuser
);
    localparam int AW = $clog2(GROUP_DEPTH);
    localparam int CW = $clog2(GROUP_DEPTH + 1);
    localparam int EW = sa_pkg::EXP_W;

    typedef enum logic [14:0] {
        S_IDLE  = 15'h0001, S_PROD = 15'h0002, S_FRAC  = 15'h0004,
        S_ELO   = 15'h0008, S_EHI  = 15'h0010, S_ESUM  = 15'h0020,
        S_DEN   = 15'h0040, S_READ = 15'h0080, S_SUB   = 15'h0100,
        S_PLO   = 15'h0200, S_PHI  = 15'h0400, S_PSUM  = 15'h0800,
        S_DIV   = 15'h1000, S_ROUND = 15'h2000, S_OUT  = 15'h4000
    } t_state;

    t_state r_state;

    // configuration
    logic [sa_pkg::BETA_W-1:0] r_beta;
    logic                      r_whole;

    // group accumulators
    logic [CW-1:0]             r_count;
    logic [sa_pkg::ISUM_W-1:0] r_isum;
    logic [sa_pkg::ESUM_W-1:0] r_esum;
    logic [EW-1:0]             r_emin;
    logic                      r_ovf;

    // exponent datapath
    logic [sa_pkg::VALUE_W-1:0] r_d;
    logic                       r_last;
    logic [20:0]                r_x;
    logic [3:0]                 r_j;
    logic [23:0]                r_frac;
    logic [43:0]                r_elo, r_ehi;

    // normalize datapath
    logic [EW-1:0]             r_mem [GROUP_DEPTH];
    logic [EW-1:0]             r_mem_q;
    logic [CW-1:0]             r_idx;
    logic [45:0]               r_den;
    logic                      r_pos;
    logic [EW-1:0]             r_diff;
    logic [49:0]               r_plo, r_phi;
    logic [45:0]               r_rem;
    logic [30:0]               r_dvd, r_q;
    logic [4:0]                r_step;
    logic [sa_pkg::OUT_W-1:0]  r_v;

    // output register
    logic                      r_ovalid;
    logic [sa_pkg::OUT_W-1:0]  r_oval;
    logic                      r_olast, r_oovf;

    // combinational helpers
    logic [40:0] x_sum;
    logic [46:0] frac_prod;
    logic [63:0] e_full;
    logic [EW-1:0] e_val;
    logic [46:0] den_prod;
    logic [69:0] p_full;
    logic [46:0] div_t;
    logic        div_ge;
    logic [4:0]  k_idx;
    logic [EW-1:0] int_e;
    logic        out_free;

    assign x_sum     = 41'(r_beta * r_d) + 41'(1 << 19);
    assign frac_prod = 47'(r_frac * sa_pkg::frac_exp(r_j)) + 47'(1 << 21);
    assign k_idx     = (r_x[20:16] > 5'd16) ? 5'd16 : r_x[20:16];
    assign int_e     = sa_pkg::int_exp(k_idx);
    assign e_full    = {r_ehi, 20'b0} + 64'(r_elo) + 64'(1 << 21);
    assign e_val     = e_full[61:22];
    assign den_prod  = 47'(r_emin * r_count);
    assign p_full    = {r_phi, 20'b0} + 70'(r_plo);
    assign div_t     = {r_rem, r_dvd[30]};
    assign div_ge    = (div_t >= {1'b0, r_den});
    assign out_free  = !r_ovalid || i_m_tready;
    assign o_pop     = (r_state == S_IDLE) && !i_empty;

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_oval};
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_oovf;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta  <= sa_pkg::BETA_RESET;
            r_whole <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sa_pkg::REG_BETA:  r_beta  <= i_cfg_data;
                sa_pkg::REG_WHOLE: r_whole <= i_cfg_data[0];
                default:           r_beta  <= r_beta;
            endcase
        end
    end

    // exponent store, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_ESUM) r_mem[r_count[AW-1:0]] <= e_val;
        if (r_state == S_READ) r_mem_q <= r_mem[r_idx[AW-1:0]];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_d    <= i_item.value;
                r_last <= i_item.last;
                r_j    <= '0;
                r_frac <= 24'(1 << 22);
            end
            S_PROD: r_x <= x_sum[40:20];
            S_FRAC: begin
                if (r_x[4'd15 - r_j]) r_frac <= frac_prod[45:22];
                r_j <= r_j + 4'd1;
            end
            S_ELO: r_elo <= 44'(int_e[19:0] * r_frac);
            S_EHI: r_ehi <= 44'(int_e[39:20] * r_frac);
            S_DEN: begin
                r_den <= r_esum - den_prod[45:0];
                r_idx <= '0;
            end
            S_READ: r_pos <= (r_den != '0) && (r_isum != '0);
            S_SUB: begin
                r_diff <= r_mem_q - r_emin;
                if (!r_pos) begin
                    if (!r_whole)                 r_v <= '0;
                    else if (r_mem_q[39:24] != '0) r_v <= '1;
                    else                          r_v <= {r_mem_q[23:0], 7'b0};
                end
            end
            S_PLO: r_plo <= 50'(r_diff[19:0] * r_isum);
            S_PHI: r_phi <= 50'(r_diff[39:20] * r_isum);
            S_PSUM: begin
                r_rem  <= 46'(p_full[69:31]);
                r_dvd  <= p_full[30:0];
                r_q    <= '0;
                r_step <= '0;
            end
            S_DIV: begin
                r_rem  <= div_ge ? 46'(div_t - {1'b0, r_den}) : div_t[45:0];
                r_q    <= {r_q[29:0], div_ge};
                r_dvd  <= {r_dvd[29:0], 1'b0};
                r_step <= r_step + 5'd1;
            end
            S_ROUND: r_v <= r_q + 31'(r_rem >= (r_den - r_rem));
            S_OUT: if (out_free) r_idx <= r_idx + CW'(1);
            default: r_v <= r_v;
        endcase
    end

    // sequencer, accumulators and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_isum   <= '0;
            r_esum   <= '0;
            r_emin   <= '1;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // S_OUT reloads the output register itself
            if (r_ovalid && i_m_tready && r_state != S_OUT) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        if (i_item.drop) begin
                            r_ovf <= 1'b1;
                            if (i_item.last) r_state <= S_DEN;
                        end else begin
                            r_state <= S_PROD;
                        end
                    end
                end
                S_PROD: r_state <= S_FRAC;
                S_FRAC: if (r_j == 4'd15) r_state <= S_ELO;
                S_ELO:  r_state <= S_EHI;
                S_EHI:  r_state <= S_ESUM;
                S_ESUM: begin
                    r_count <= r_count + CW'(1);
                    r_isum  <= r_isum + sa_pkg::ISUM_W'(r_d);
                    r_esum  <= r_esum + sa_pkg::ESUM_W'(e_val);
                    if (e_val < r_emin) r_emin <= e_val;
                    r_state <= r_last ? S_DEN : S_IDLE;
                end
                S_DEN:  r_state <= S_READ;
                S_READ: r_state <= S_SUB;
                S_SUB:  r_state <= r_pos ? S_PLO : S_OUT;
                S_PLO:  r_state <= S_PHI;
                S_PHI:  r_state <= S_PSUM;
                S_PSUM: r_state <= S_DIV;
                S_DIV:  if (r_step == 5'd30) r_state <= S_ROUND;
                S_ROUND: r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= r_v;
                        r_olast  <= (r_idx + CW'(1) == r_count);
                        r_oovf   <= r_ovf;
                        if (r_idx + CW'(1) == r_count) begin
                            r_count <= '0;
                            r_isum  <= '0;
                            r_esum  <= '0;
                            r_emin  <= '1;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/soft_argmax_normalizer.sv =====
// ----------------------------------------------------------------------------
// soft_argmax_normalizer: sum-preserving soft argmax of a sample group
// Front classifies samples, a queue decouples, back computes exp and emits.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | tdata[23:0] in_value, tlast in_last
//  m_*      | out       | tdata[30:0] out_value, tlast out_last, tuser overflow
//  cfg_*    | in        | index 0 beta_magnitude, index 1 whole_mode
//
// A stored sample runs the beta multiply, fraction loop, exponent halves and
// accumulation; a dropped sample only sets overflow. Each result runs read,
// subtract, product halves, sum, the 31-step bit-serial divider and rounding;
// results lacking a positive factor skip to output. Reset is synchronous,
// active low, clears all control. The 4-entry queue takes input while the back
// end works or output stalls, until full; a held result blocks only the next.
module soft_argmax_normalizer #(
    parameter int GROUP_DEPTH = sa_pkg::GROUP_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [23:0] in_value
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [30:0] out_value, [31] zero
    output logic        o_m_tlast,
    output logic        o_m_tuser    // [0] group_overflow
);
    sa_pkg::t_sample push_item, pop_item;
    logic            push, pop, full, empty;

    sa_front #(.GROUP_DEPTH(GROUP_DEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tlast(i_s_tlast),
        .i_full(full), .o_push(push), .o_item(push_item)
    );

    sa_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_item(push_item), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_item(pop_item)
    );

    sa_back #(.GROUP_DEPTH(GROUP_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .i_empty(empty), .i_item(pop_item), .o_pop(pop),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tlast(o_m_tlast), .o_m_tuser(o_m_tuser)
    );
endmodule

// ===== hdl/sa_checker.sv =====
// ----------------------------------------------------------------------------
// sa_checker: port-level assertions for the soft argmax normalizer
// Watches the output channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module sa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic        o_m_tuser
);
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // pad bit of the result stays clear
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_m_tdata[31])
        else $error("result pad bit set");

    // reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");
endmodule

bind soft_argmax_normalizer sa_checker u_sa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
    .o_m_tlast(o_m_tlast), .o_m_tuser(o_m_tuser)
);
